### rtl/core/dtre_pkg.sv
// ----------------------------------------------------------------------------
// dtre_pkg
// Shared types and default geometry for the dirty tile run rectangle emitter.
// ----------------------------------------------------------------------------
package dtre_pkg;

  // default tile grid geometry
  localparam int TILE_COLS_DEF   = 32;
  localparam int TILE_ROWS_DEF   = 16;
  localparam int TILE_WIDTH_DEF  = 16;
  localparam int TILE_HEIGHT_DEF = 16;

  // width of the dirty mask word
  localparam int MASK_W = 32;
  localparam int POS_W  = $clog2(MASK_W);
  localparam int LEN_W  = POS_W + 1;

  // one incoming tile row item
  typedef struct packed {
    logic [3:0]        tile_row;
    logic [MASK_W-1:0] dirty_mask;
  } row_item_t;

  // one outgoing rectangle item
  typedef struct packed {
    logic [8:0] rect_x;
    logic [7:0] rect_y;
    logic [9:0] rect_width;
    logic       stage_buffer;
    logic       last_in_row;
  } rect_item_t;

  // run found by the scanner in the current cycle
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] first;
    logic [LEN_W-1:0] len;
    logic             last;
  } run_evt_t;

endpackage

### rtl/core/dtre_run_scan.sv
// ----------------------------------------------------------------------------
// dtre_run_scan
// Bit-serial run finder: shifts the mask down one column per cycle while
// advance is high and reports each run of set bits as it closes.
// ----------------------------------------------------------------------------
module dtre_run_scan
  import dtre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [MASK_W-1:0] load_mask,
  input  logic              active,
  input  logic              advance,
  output run_evt_t          evt,
  output logic              drained
);

  logic [MASK_W-1:0] mask;
  logic [POS_W-1:0]  pos;
  logic              in_run;
  logic [POS_W-1:0]  first;
  logic [LEN_W-1:0]  run_len;

  // nothing left above the column under test
  assign drained = (mask[MASK_W-1:1] == '0);

  // a run closes where a set bit is followed by a clear one
  always_comb begin
    evt.hit   = active && mask[0] && !mask[1];
    evt.first = in_run ? first : pos;
    evt.len   = run_len + LEN_W'(1);
    evt.last  = drained;
  end

  // shift one column per step, tracking the open run
  always_ff @(posedge clk) begin
    if (rst) begin
      mask    <= '0;
      pos     <= '0;
      in_run  <= 1'b0;
      run_len <= '0;
    end else if (load) begin
      mask    <= load_mask;
      pos     <= '0;
      in_run  <= 1'b0;
      run_len <= '0;
    end else if (advance) begin
      mask <= {1'b0, mask[MASK_W-1:1]};
      pos  <= pos + POS_W'(1);
      if (mask[0]) begin
        if (!in_run) begin
          first <= pos;
        end
        if (mask[1]) begin
          in_run  <= 1'b1;
          run_len <= run_len + LEN_W'(1);
        end else begin
          in_run  <= 1'b0;
          run_len <= '0;
        end
      end
    end
  end

endmodule

### rtl/core/dtre_out_reg.sv
// ----------------------------------------------------------------------------
// dtre_out_reg
// Output holding register for rectangle items on the valid/stall channel.
// ----------------------------------------------------------------------------
module dtre_out_reg
  import dtre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  rect_item_t d,
  input  logic       stall,
  output logic       valid,
  output rect_item_t q,
  output logic       blocked
);

  // held item cannot leave this cycle
  assign blocked = valid && stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

### rtl/core/dirty_tile_run_rect_emitter_core.sv
// ----------------------------------------------------------------------------
// dirty_tile_run_rect_emitter_core
// Splits a tile row dirty mask into runs and emits one pixel rectangle per
// run, with ping-pong staging buffer select and last-in-row flag.
// ----------------------------------------------------------------------------
//  channel  | signals                         | item
//  ---------+---------------------------------+---------------------------
//  src      | src_valid, src_stall, src_item  | tile_row, dirty_mask
//  dst      | dst_valid, dst_stall, dst_item  | one rectangle per run
//
// The scanner steps a row item one column per cycle, unless stalled, up to h,
// the highest dirty column in range, as dtre_run_scan shifts the mask down.
// A zero mask or out-of-grid row is accepted without a scan and emits nothing.
// src_stall is high while a row is being scanned. A stalled rectangle in the
// output register halts the scan only when the next run closes.
// Reset (rst, synchronous) clears the sequencer, output valid and buffer select.
// ----------------------------------------------------------------------------
module dirty_tile_run_rect_emitter_core
  import dtre_pkg::*;
#(
  parameter int TILE_COLS   = TILE_COLS_DEF,
  parameter int TILE_ROWS   = TILE_ROWS_DEF,
  parameter int TILE_WIDTH  = TILE_WIDTH_DEF,
  parameter int TILE_HEIGHT = TILE_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  row_item_t  src_item,
  output logic       dst_valid,
  input  logic       dst_stall,
  output rect_item_t dst_item
);

  // columns that exist in the mask word
  localparam logic [MASK_W-1:0] COL_MASK =
    (TILE_COLS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << TILE_COLS) - 64'd1);
  localparam logic [6:0] ROWS_LIM = 7'(TILE_ROWS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  logic              accept;
  logic              start;
  logic [MASK_W-1:0] in_mask;
  logic [9:0]        y_full;
  logic [7:0]        rect_y;
  logic              stage_select;
  run_evt_t          evt;
  logic              drained;
  logic              advance;
  logic              emit;
  logic              out_blocked;
  logic [11:0]       x_full;
  logic [12:0]       w_full;
  rect_item_t        rect;

  // input acceptance and row filtering
  assign src_stall = (state != ST_IDLE);
  assign accept    = src_valid && !src_stall;
  assign in_mask   = src_item.dirty_mask & COL_MASK;
  assign start     = accept && (in_mask != '0) && ({3'b0, src_item.tile_row} < ROWS_LIM);
  assign y_full    = 10'(src_item.tile_row) * 10'(TILE_HEIGHT);

  // scan steps unless a closing run would meet a blocked output
  assign advance = (state == ST_SCAN) && !(evt.hit && out_blocked);
  assign emit    = evt.hit && advance;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: if (advance && drained) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stage_select <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        stage_select <= ~stage_select;
      end
    end
  end

  // row origin is fixed for the whole scan
  always_ff @(posedge clk) begin
    if (start) begin
      rect_y <= y_full[7:0];
    end
  end

  dtre_run_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .load      (start),
    .load_mask (in_mask),
    .active    (state == ST_SCAN),
    .advance   (advance),
    .evt       (evt),
    .drained   (drained)
  );

  // pixel geometry of the closing run
  assign x_full = 12'(evt.first) * 12'(TILE_WIDTH);
  assign w_full = 13'(evt.len) * 13'(TILE_WIDTH);

  always_comb begin
    rect.rect_x       = x_full[8:0];
    rect.rect_y       = rect_y;
    rect.rect_width   = w_full[9:0];
    rect.stage_buffer = stage_select;
    rect.last_in_row  = evt.last;
  end

  dtre_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (emit),
    .d       (rect),
    .stall   (dst_stall),
    .valid   (dst_valid),
    .q       (dst_item),
    .blocked (out_blocked)
  );

endmodule
